// ----- hdl/rect_feature_projection_unit_defines.svh -----
// Assertion macros for the rect feature projection unit checker.
// Included by rfp_chk.sv; depends on nothing else.
`ifndef RECT_FEATURE_PROJECTION_UNIT_DEFINES_SVH
`define RECT_FEATURE_PROJECTION_UNIT_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define RFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define RFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/rfp_pkg.sv -----
// Shared constants, request codes and types of the rect feature projection unit.
// No dependencies.
package rfp_pkg;

  localparam int NumFeaturesDef = 128;
  localparam int MaxRectsDef    = 16;
  localparam int ImageSideDef   = 64;

  localparam int ReqTypeW = 2;
  localparam int ImgAddrW = 12;
  localparam int PixW     = 32;
  localparam int FeatW    = 7;
  localparam int SlotW    = 4;
  localparam int CoordW   = 6;
  localparam int WeightW  = 24;
  localparam int CountW   = 5;
  localparam int BoxW     = PixW + 2;
  localparam int ProdW    = BoxW + WeightW;
  localparam int SumW     = 64;

  typedef enum logic [ReqTypeW-1:0] {
    REQ_IMAGE   = 2'd0,
    REQ_RECT    = 2'd1,
    REQ_COMPUTE = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    BOX_LOAD = 2'd0,
    BOX_ADD  = 2'd1,
    BOX_SUB  = 2'd2
  } box_op_e;

  typedef struct packed {
    logic    box_en;
    box_op_e box_op;
    logic    mul_en;
    logic    acc_clr;
    logic    acc_en;
  } mac_ctl_t;

  typedef struct packed {
    logic [CoordW-1:0]         x1;
    logic [CoordW-1:0]         y1;
    logic [CoordW-1:0]         x2;
    logic [CoordW-1:0]         y2;
    logic signed [WeightW-1:0] weight;
  } rect_t;

endpackage

// ----- hdl/rfp_if.sv -----
// Request and result channel interfaces of the rect feature projection unit.
// Depends on rfp_pkg.
interface rfp_req_if import rfp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [ReqTypeW-1:0]       req_type;
  logic [ImgAddrW-1:0]       image_addr;
  logic signed [PixW-1:0]    image_value;
  logic [FeatW-1:0]          feature_index;
  logic [SlotW-1:0]          rect_slot;
  logic [CoordW-1:0]         corner_x1;
  logic [CoordW-1:0]         corner_y1;
  logic [CoordW-1:0]         corner_x2;
  logic [CoordW-1:0]         corner_y2;
  logic signed [WeightW-1:0] rect_weight;
  logic [CountW-1:0]         rect_count;

  modport source (
    output valid, req_type, image_addr, image_value, feature_index, rect_slot,
           corner_x1, corner_y1, corner_x2, corner_y2, rect_weight, rect_count,
    input  ready
  );
  modport sink (
    input  valid, req_type, image_addr, image_value, feature_index, rect_slot,
           corner_x1, corner_y1, corner_x2, corner_y2, rect_weight, rect_count,
    output ready
  );
  modport monitor (
    input valid, ready, req_type, image_addr, image_value, feature_index, rect_slot,
          corner_x1, corner_y1, corner_x2, corner_y2, rect_weight, rect_count
  );
endinterface

interface rfp_res_if import rfp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [FeatW-1:0]       result_index;
  logic signed [SumW-1:0] feature_value;

  modport source (output valid, result_index, feature_value, input ready);
  modport sink   (input valid, result_index, feature_value, output ready);
  modport monitor (input valid, ready, result_index, feature_value);
endinterface

// ----- hdl/rfp_mem.sv -----
// Integral image store, rectangle table and rectangle count table.
// Single write and single registered read port each; depends on rfp_pkg.
module rfp_mem import rfp_pkg::*; #(
  parameter int NUM_FEATURES = NumFeaturesDef,
  parameter int MAX_RECTS    = MaxRectsDef,
  parameter int IMAGE_SIDE   = ImageSideDef
) (
  input  logic                                     clk_i,
  input  logic                                     img_we_i,
  input  logic [$clog2(IMAGE_SIDE*IMAGE_SIDE)-1:0] img_waddr_i,
  input  logic signed [PixW-1:0]                   img_wdata_i,
  input  logic [$clog2(IMAGE_SIDE*IMAGE_SIDE)-1:0] img_raddr_i,
  output logic signed [PixW-1:0]                   img_rdata_o,
  input  logic                                     rect_we_i,
  input  logic [$clog2(NUM_FEATURES*MAX_RECTS)-1:0] rect_waddr_i,
  input  rect_t                                    rect_wdata_i,
  input  logic [$clog2(NUM_FEATURES*MAX_RECTS)-1:0] rect_raddr_i,
  output rect_t                                    rect_rdata_o,
  input  logic                                     cnt_we_i,
  input  logic [((NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1)-1:0] cnt_waddr_i,
  input  logic [$clog2(MAX_RECTS+1)-1:0]           cnt_wdata_i,
  input  logic [((NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1)-1:0] cnt_raddr_i,
  output logic [$clog2(MAX_RECTS+1)-1:0]           cnt_rdata_o
);

  localparam int ImgWords  = IMAGE_SIDE * IMAGE_SIDE;
  localparam int RectWords = NUM_FEATURES * MAX_RECTS;
  localparam int CntW      = $clog2(MAX_RECTS + 1);

  logic signed [PixW-1:0] img_mem  [ImgWords];
  rect_t                  rect_mem [RectWords];
  logic [CntW-1:0]        cnt_mem  [NUM_FEATURES];

  always_ff @(posedge clk_i) begin
    if (img_we_i) begin
      img_mem[img_waddr_i] <= img_wdata_i;
    end
    img_rdata_o <= img_mem[img_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (rect_we_i) begin
      rect_mem[rect_waddr_i] <= rect_wdata_i;
    end
    rect_rdata_o <= rect_mem[rect_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we_i) begin
      cnt_mem[cnt_waddr_i] <= cnt_wdata_i;
    end
    cnt_rdata_o <= cnt_mem[cnt_raddr_i];
  end

endmodule

// ----- hdl/rfp_mac.sv -----
// Shared box-sum, multiply and accumulate unit of the feature computation.
// Driven step by step by the sequencer in the top level; depends on rfp_pkg.
module rfp_mac import rfp_pkg::*; (
  input  logic                      clk_i,
  input  mac_ctl_t                  ctl_i,
  input  logic signed [PixW-1:0]    pix_i,
  input  logic signed [WeightW-1:0] weight_i,
  output logic signed [SumW-1:0]    sum_o
);

  logic signed [BoxW-1:0]  box_q, box_d, pix_x;
  logic signed [ProdW-1:0] prod_q;
  logic signed [SumW-1:0]  acc_q;

  assign pix_x = BoxW'(pix_i);

  always_comb begin
    case (ctl_i.box_op)
      BOX_LOAD: box_d = pix_x;
      BOX_ADD:  box_d = box_q + pix_x;
      BOX_SUB:  box_d = box_q - pix_x;
      default:  box_d = box_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.box_en) begin
      box_q <= box_d;
    end
    if (ctl_i.mul_en) begin
      prod_q <= box_q * weight_i;
    end
    if (ctl_i.acc_clr) begin
      acc_q <= '0;
    end else if (ctl_i.acc_en) begin
      acc_q <= acc_q + SumW'(prod_q);
    end
  end

  assign sum_o = acc_q;

endmodule

// ----- hdl/rect_feature_projection_unit.sv -----
// Top level of the rect feature projection unit: request decode and sequencer.
// Depends on rfp_pkg, rfp_if, rfp_mem and rfp_mac.
//
// Usage:
// - req_i takes one request word per handshake: image word write, rectangle
//   entry write (corners, signed weight, count) or feature compute.
// - Writes leave the unit idle; ready stays high and the next word follows at once.
// - A compute reads the feature's count, then walks its rectangles through one
//   shared box-sum/multiply/accumulate unit, fed by the single image read port.
//   Each rectangle steps through an entry read, four corner reads, a multiply
//   and an accumulate; ready is low from acceptance until the result is loaded
//   into the output register.
// - Results leave on res_o from an output register. While the receiver stalls,
//   the register holds its word and the unit still takes writes; a compute
//   that finishes waits for the register to drain.
// - Weights are fixed point; results carry the same fractional bits.
// - After reset the count table is cleared, one entry a cycle: ready stays low
//   until every entry is cleared. Image and rectangle entries read before
//   written are undefined.
module rect_feature_projection_unit import rfp_pkg::*; #(
  parameter int NUM_FEATURES = NumFeaturesDef,
  parameter int MAX_RECTS    = MaxRectsDef,
  parameter int IMAGE_SIDE   = ImageSideDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  rfp_req_if.sink   req_i,
  rfp_res_if.source res_o
);

  localparam int ImgWords  = IMAGE_SIDE * IMAGE_SIDE;
  localparam int ImgAw     = $clog2(ImgWords);
  localparam int RectAw    = $clog2(NUM_FEATURES * MAX_RECTS);
  localparam int FeatAw    = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam int CntW      = $clog2(MAX_RECTS + 1);
  localparam int CoordMaxI = (IMAGE_SIDE - 1 < (1 << CoordW) - 1) ?
                             IMAGE_SIDE - 1 : (1 << CoordW) - 1;
  localparam logic [CoordW-1:0] CoordMax = CoordW'(CoordMaxI);

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_COUNT = 8'b0000_0100,
    ST_RECT  = 8'b0000_1000,
    ST_PIX   = 8'b0001_0000,
    ST_MUL   = 8'b0010_0000,
    ST_ACC   = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [FeatAw-1:0] clr_idx_q, clr_idx_d;
  logic [CntW-1:0]   k_q, k_nxt, k_rd, n_q;
  logic [1:0]        corner_q, sel;
  logic [FeatW-1:0]  fi_q;
  rect_t             rect_q, ent;
  logic [CoordW-1:0] row, col;

  logic              req_fire, fi_ok, slot_ok, cmp_go, res_free, fin_load;
  logic              res_valid_q;
  logic [FeatW-1:0]  res_idx_q;
  logic signed [SumW-1:0] res_val_q, sum;

  logic                   img_we;
  logic [ImgAw-1:0]       img_waddr, img_raddr;
  logic signed [PixW-1:0] img_rdata;
  logic                   rect_we;
  logic [RectAw-1:0]      rect_waddr, rect_raddr;
  rect_t                  rect_wdata, rect_rdata;
  logic                   cnt_we;
  logic [FeatAw-1:0]      cnt_waddr, cnt_raddr;
  logic [CntW-1:0]        cnt_wdata, cnt_rdata, cnt_sat;
  mac_ctl_t               mac_ctl;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign fi_ok       = int'(req_i.feature_index) < NUM_FEATURES;
  assign slot_ok     = int'(req_i.rect_slot) < MAX_RECTS;
  assign cmp_go      = req_fire && (req_type_e'(req_i.req_type) == REQ_COMPUTE) && fi_ok;
  assign res_free    = !res_valid_q || res_o.ready;
  assign fin_load    = (state_q == ST_FIN) && res_free;

  // Request writes
  assign img_we     = req_fire && (req_type_e'(req_i.req_type) == REQ_IMAGE) &&
                      (int'(req_i.image_addr) < ImgWords);
  assign img_waddr  = ImgAw'(req_i.image_addr);
  assign rect_we    = req_fire && (req_type_e'(req_i.req_type) == REQ_RECT) &&
                      fi_ok && slot_ok;
  assign rect_waddr = RectAw'(req_i.feature_index) * RectAw'(MAX_RECTS) +
                      RectAw'(req_i.rect_slot);
  assign cnt_sat    = (int'(req_i.rect_count) > MAX_RECTS) ?
                      CntW'(MAX_RECTS) : CntW'(req_i.rect_count);

  always_comb begin
    rect_wdata.x1     = (req_i.corner_x1 > CoordMax) ? CoordMax : req_i.corner_x1;
    rect_wdata.y1     = (req_i.corner_y1 > CoordMax) ? CoordMax : req_i.corner_y1;
    rect_wdata.x2     = (req_i.corner_x2 > CoordMax) ? CoordMax : req_i.corner_x2;
    rect_wdata.y2     = (req_i.corner_y2 > CoordMax) ? CoordMax : req_i.corner_y2;
    rect_wdata.weight = req_i.rect_weight;
  end

  assign cnt_we    = (state_q == ST_CLEAR) || rect_we;
  assign cnt_waddr = (state_q == ST_CLEAR) ? clr_idx_q : FeatAw'(req_i.feature_index);
  assign cnt_wdata = (state_q == ST_CLEAR) ? '0 : cnt_sat;
  assign cnt_raddr = FeatAw'(req_i.feature_index);

  // Read addressing for the rectangle walk
  assign k_nxt      = k_q + 1'b1;
  assign k_rd       = ((state_q == ST_ACC) && (k_nxt < n_q)) ? k_nxt : k_q;
  assign rect_raddr = RectAw'(fi_q) * RectAw'(MAX_RECTS) + RectAw'(k_rd);

  always_comb begin
    ent = (state_q == ST_RECT) ? rect_rdata : rect_q;
    sel = (state_q == ST_RECT) ? 2'd0 : corner_q + 2'd1;
    case (sel)
      2'd0: begin
        row = ent.y1;
        col = ent.x1;
      end
      2'd1: begin
        row = ent.y2;
        col = ent.x2;
      end
      2'd2: begin
        row = ent.y1;
        col = ent.x2;
      end
      default: begin
        row = ent.y2;
        col = ent.x1;
      end
    endcase
    img_raddr = ImgAw'(row) * ImgAw'(IMAGE_SIDE) + ImgAw'(col);
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    mac_ctl   = '0;
    case (state_q)
      ST_CLEAR: begin
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == FeatAw'(NUM_FEATURES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmp_go) begin
          state_d = ST_COUNT;
        end
      end
      ST_COUNT: begin
        mac_ctl.acc_clr = 1'b1;
        state_d = (cnt_rdata == '0) ? ST_FIN : ST_RECT;
      end
      ST_RECT: begin
        state_d = ST_PIX;
      end
      ST_PIX: begin
        mac_ctl.box_en = 1'b1;
        mac_ctl.box_op = (corner_q == 2'd0) ? BOX_LOAD :
                         (corner_q == 2'd1) ? BOX_ADD : BOX_SUB;
        if (corner_q == 2'd3) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        mac_ctl.mul_en = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        mac_ctl.acc_en = 1'b1;
        state_d = (k_nxt < n_q) ? ST_RECT : ST_FIN;
      end
      ST_FIN: begin
        if (res_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      k_q         <= '0;
      corner_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      if (cmp_go) begin
        k_q <= '0;
      end else if (state_q == ST_ACC) begin
        k_q <= k_nxt;
      end
      if (state_q == ST_RECT) begin
        corner_q <= '0;
      end else if (state_q == ST_PIX) begin
        corner_q <= corner_q + 2'd1;
      end
      if (fin_load) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_go) begin
      fi_q <= req_i.feature_index;
    end
    if (state_q == ST_COUNT) begin
      n_q <= cnt_rdata;
    end
    if (state_q == ST_RECT) begin
      rect_q <= rect_rdata;
    end
    if (fin_load) begin
      res_idx_q <= fi_q;
      res_val_q <= sum;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.result_index  = res_idx_q;
  assign res_o.feature_value = res_val_q;

  rfp_mem #(
    .NUM_FEATURES(NUM_FEATURES),
    .MAX_RECTS   (MAX_RECTS),
    .IMAGE_SIDE  (IMAGE_SIDE)
  ) u_mem (
    .clk_i       (clk_i),
    .img_we_i    (img_we),
    .img_waddr_i (img_waddr),
    .img_wdata_i (req_i.image_value),
    .img_raddr_i (img_raddr),
    .img_rdata_o (img_rdata),
    .rect_we_i   (rect_we),
    .rect_waddr_i(rect_waddr),
    .rect_wdata_i(rect_wdata),
    .rect_raddr_i(rect_raddr),
    .rect_rdata_o(rect_rdata),
    .cnt_we_i    (cnt_we),
    .cnt_waddr_i (cnt_waddr),
    .cnt_wdata_i (cnt_wdata),
    .cnt_raddr_i (cnt_raddr),
    .cnt_rdata_o (cnt_rdata)
  );

  rfp_mac u_mac (
    .clk_i   (clk_i),
    .ctl_i   (mac_ctl),
    .pix_i   (img_rdata),
    .weight_i(rect_q.weight),
    .sum_o   (sum)
  );

endmodule

// ----- hdl/rfp_chk.sv -----
// Port-level checker of the rect feature projection unit, bound to the top level.
// Depends on rfp_pkg, rfp_if and rect_feature_projection_unit_defines.svh.
`include "rect_feature_projection_unit_defines.svh"

module rfp_chk import rfp_pkg::*; #(
  parameter int NUM_FEATURES = NumFeaturesDef
) (
  input logic       clk_i,
  input logic       rst_ni,
  rfp_req_if.sink   req_i,
  rfp_res_if.source res_o
);

  logic req_fire, cmp_fire, res_stall;

  assign req_fire  = req_i.valid && req_i.ready;
  assign cmp_fire  = req_fire && (req_i.req_type == REQ_COMPUTE) &&
                     (int'(req_i.feature_index) < NUM_FEATURES);
  assign res_stall = res_o.valid && !res_o.ready;

  `RFP_ASSERT_NXT(a_res_hold, clk_i, rst_ni, res_stall,
    res_o.valid && $stable(res_o.result_index) && $stable(res_o.feature_value),
    "result word dropped or changed while stalled")

  `RFP_ASSERT_NXT(a_cmp_busy, clk_i, rst_ni, cmp_fire, !req_i.ready,
    "ready still high after compute accepted")

  `RFP_ASSERT_NXT(a_no_early_res, clk_i, rst_ni, req_fire, !$rose(res_o.valid),
    "result appeared right after a request")

  `RFP_ASSERT_NOW(a_res_after_busy, clk_i, rst_ni, $rose(res_o.valid), $past(!req_i.ready),
    "result appeared without a compute in flight")

  `RFP_ASSERT_NOW(a_res_index, clk_i, rst_ni, res_o.valid,
    int'(res_o.result_index) < NUM_FEATURES, "result index beyond feature count")

endmodule

bind rect_feature_projection_unit rfp_chk #(
  .NUM_FEATURES(NUM_FEATURES)
) u_rfp_chk (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .req_i (req_i),
  .res_o (res_o)
);
